// ===== hdl/convex_hull_scan_core_assert.svh =====
// ============================================================================
// Assertion macros for the convex hull scan core.
// Shared implication forms used by the core RTL.
// ============================================================================
`ifndef CONVEX_HULL_SCAN_CORE_ASSERT_SVH
`define CONVEX_HULL_SCAN_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define CHS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/chs_pkg.sv =====
// ============================================================================
// Convex hull scan package
// Shared types and codes for the convex hull scan core.
// ============================================================================
`default_nettype none
package chs_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MIN_RD,
        ST_MIN,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_MOVE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_EMIT_RD,
        ST_EMIT
    } chs_state_t;

endpackage
`default_nettype wire

// ===== hdl/convex_hull_scan_core.sv =====
// A set of n points loads at one item per cycle; after the final item the core
// searches for the origin, insertion-sorts the points through the work memory,
// scans them with a stack and outputs the hull vertices. busy is high from the
// final item until the last vertex.
// Results cannot be stalled; hull_end flags the last vertex of a run.
// Reset clears the state machine, counters, origin and output flags; memory contents are undefined until written.
`default_nettype none
module convex_hull_scan_core
    import chs_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    input  wire logic                         final_point,
    output logic                              strobe,
    output logic signed [COORD_BITS-1:0]      hull_x,
    output logic signed [COORD_BITS-1:0]      hull_y,
    output logic                              hull_end
);

`include "convex_hull_scan_core_assert.svh"

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = 2 * COORD_BITS;

    chs_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next, i_reg, i_next, k_reg, k_next;
    logic [CW-1:0] m_reg, m_next, top_reg, top_next, e_reg, e_next;
    logic [PW-1:0] o_reg, o_next, p_reg, p_next, s1_reg, s1_next, s0_reg, s0_next;
    logic          strobe_reg, strobe_next, end_reg, end_next;
    logic [PW-1:0] hv_reg, hv_next;
    logic          s0_pop_reg;

    logic          pw_we, ww_we, sw_we;
    logic [AW-1:0] pw_a, pr_a, ww_a, wr_a, sw_a, sr_a;
    logic [PW-1:0] pw_d, ww_d, sw_d, pr_d, wr_d, sr_d;

    logic [COORD_BITS-1:0] tox, toy, tax, tay, tbx, tby;
    logic tl, tc, tn;

    chs_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pts (.clk(clk), .we(pw_we),
        .waddr(pw_a), .wdata(pw_d), .raddr(pr_a), .rdata(pr_d));
    chs_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_work (.clk(clk), .we(ww_we),
        .waddr(ww_a), .wdata(ww_d), .raddr(wr_a), .rdata(wr_d));
    chs_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_stk (.clk(clk), .we(sw_we),
        .waddr(sw_a), .wdata(sw_d), .raddr(sr_a), .rdata(sr_d));

    chs_turn #(.CB(COORD_BITS)) u_turn (.clk(clk), .ox(tox), .oy(toy), .ax(tax),
        .ay(tay), .bx(tbx), .by(tby), .left(tl), .colin(tc), .nearer(tn));

    // Points pack as {x, y}.
    function automatic logic lower(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic signed [COORD_BITS-1:0] ax, ay, bx, by;
        ax = a[PW-1:COORD_BITS];
        ay = a[COORD_BITS-1:0];
        bx = b[PW-1:COORD_BITS];
        by = b[COORD_BITS-1:0];
        return (ay < by) || (ay == by && ax < bx);
    endfunction

    logic accept;
    logic turn_le;
    assign accept = start && !busy;
    assign busy = (state_reg != ST_LOAD);
    assign strobe = strobe_reg;
    assign hull_x = hv_reg[PW-1:COORD_BITS];
    assign hull_y = hv_reg[COORD_BITS-1:0];
    assign hull_end = end_reg;
    assign turn_le = !tl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            cnt_reg    <= '0;
            i_reg      <= '0;
            k_reg      <= '0;
            m_reg      <= '0;
            top_reg    <= '0;
            e_reg      <= '0;
            strobe_reg <= 1'b0;
            end_reg    <= 1'b0;
            o_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            i_reg      <= i_next;
            k_reg      <= k_next;
            m_reg      <= m_next;
            top_reg    <= top_next;
            e_reg      <= e_next;
            strobe_reg <= strobe_next;
            end_reg    <= end_next;
            o_reg      <= o_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg  <= p_next;
        s1_reg <= s1_next;
        s0_reg <= s0_next;
        hv_reg <= hv_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        m_next      = m_reg;
        top_next    = top_reg;
        e_next      = e_reg;
        o_next      = o_reg;
        p_next      = p_reg;
        s1_next     = s1_reg;
        s0_next     = s0_reg;
        hv_next     = hv_reg;
        strobe_next = 1'b0;
        end_next    = 1'b0;
        pw_we = 1'b0;
        pw_a  = cnt_reg[AW-1:0];
        pw_d  = {point_x, point_y};
        pr_a  = i_reg[AW-1:0];
        ww_we = 1'b0;
        ww_a  = k_reg[AW-1:0];
        ww_d  = p_reg;
        wr_a  = k_reg[AW-1:0] - AW'(1);
        sw_we = 1'b0;
        sw_a  = top_reg[AW-1:0];
        sw_d  = p_reg;
        sr_a  = top_reg[AW-1:0] - AW'(2);
        tox = o_reg[PW-1:COORD_BITS];
        toy = o_reg[COORD_BITS-1:0];
        tax = p_reg[PW-1:COORD_BITS];
        tay = p_reg[COORD_BITS-1:0];
        tbx = wr_d[PW-1:COORD_BITS];
        tby = wr_d[COORD_BITS-1:0];
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (cnt_reg < CW'(MAX_POINTS))
                    begin
                        pw_we = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (final_point)
                    begin
                        i_next = '0;
                        state_next = ST_MIN_RD;
                    end
                end
            end
            ST_MIN_RD:
            begin
                i_next = i_reg + CW'(1);
                state_next = ST_MIN;
            end
            ST_MIN:
            begin
                if (i_reg == CW'(1) || lower(pr_d, o_reg))
                begin
                    o_next = pr_d;
                end
                if (i_reg == cnt_reg)
                begin
                    i_next = '0;
                    m_next = '0;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                end
            end
            ST_INS_RD:
            begin
                if (i_reg == cnt_reg)
                begin
                    top_next = '0;
                    p_next = o_reg;
                    i_next = '0;
                    state_next = ST_SCAN_CMP;
                    sw_we = 1'b1;
                    sw_a = '0;
                    sw_d = o_reg;
                end
                else
                begin
                    state_next = ST_INS_CMP;
                    k_next = m_reg;
                    e_next = '0;
                end
            end
            ST_INS_CMP:
            begin
                // e_reg sequences: 0 latch point, 1 and 2 read wait, 3 compare ready.
                if (e_reg == CW'(0))
                begin
                    p_next = pr_d;
                    if (pr_d == o_reg)
                    begin
                        i_next = i_reg + CW'(1);
                        state_next = ST_INS_RD;
                    end
                    else
                    begin
                        e_next = CW'(1);
                    end
                end
                else if (e_reg == CW'(1))
                begin
                    e_next = CW'(2);
                end
                else if (e_reg == CW'(2))
                begin
                    e_next = CW'(3);
                end
                else
                begin
                    e_next = CW'(1);
                    if (k_reg != '0 && (tl || (tc && tn)))
                    begin
                        ww_we = 1'b1;
                        ww_d = wr_d;
                        k_next = k_reg - CW'(1);
                    end
                    else
                    begin
                        state_next = ST_INS_MOVE;
                    end
                end
            end
            ST_INS_MOVE:
            begin
                ww_we = 1'b1;
                m_next = m_reg + CW'(1);
                i_next = i_reg + CW'(1);
                state_next = ST_INS_RD;
            end
            ST_SCAN_RD:
            begin
                // Read work[i]; stack top and second are held in registers.
                wr_a = i_reg[AW-1:0];
                state_next = ST_SCAN_CMP;
                e_next = '0;
            end
            ST_SCAN_CMP:
            begin
                wr_a = i_reg[AW-1:0];
                tox = s0_reg[PW-1:COORD_BITS];
                toy = s0_reg[COORD_BITS-1:0];
                tax = s1_reg[PW-1:COORD_BITS];
                tay = s1_reg[COORD_BITS-1:0];
                if (top_reg == '0)
                begin
                    top_next = CW'(1);
                    s1_next = o_reg;
                    if (m_reg == '0)
                    begin
                        e_next = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        e_next = CW'(1);
                    end
                end
                else if (e_reg == CW'(0))
                begin
                    if (s0_pop_reg)
                    begin
                        s0_next = sr_d;
                    end
                    e_next = CW'(1);
                end
                else if (e_reg == CW'(1))
                begin
                    e_next = CW'(2);
                end
                else if (e_reg == CW'(2))
                begin
                    e_next = CW'(3);
                end
                else if (top_reg >= CW'(2) && turn_le)
                begin
                    top_next = top_reg - CW'(1);
                    s1_next = s0_reg;
                    sr_a = top_reg[AW-1:0] - AW'(3);
                    e_next = CW'(4);
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    sw_we = 1'b1;
                    sw_d = wr_d;
                    s0_next = s1_reg;
                    s1_next = wr_d;
                    top_next = top_reg + CW'(1);
                    i_next = i_reg + CW'(1);
                    e_next = CW'(1);
                    if (i_reg + CW'(1) == m_reg)
                    begin
                        e_next = '0;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_EMIT_RD:
            begin
                sr_a = e_reg[AW-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                sr_a = e_reg[AW-1:0];
                strobe_next = 1'b1;
                hv_next = sr_d;
                end_next = (e_reg + CW'(1) == top_reg);
                if (e_reg + CW'(1) == top_reg)
                begin
                    cnt_next = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    e_next = e_reg + CW'(1);
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        if (state_reg == ST_SCAN_RD && e_reg == CW'(4))
        begin
            sr_a = top_reg[AW-1:0] - AW'(2);
        end
    end

    // Second stack entry is reloaded from memory after a pop.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN_RD && e_reg == CW'(4))
        begin
            s0_pop_reg <= 1'b1;
        end
        else
        begin
            s0_pop_reg <= 1'b0;
        end
    end

    `CHS_ASSERT_IMP(a_strobe_busy, strobe_reg && !end_reg, busy,
        "hull item strobed while idle")
    `CHS_ASSERT_NEXT(a_end_idle, strobe_reg && end_reg, !strobe_reg,
        "item after last hull vertex")
    `CHS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CW'(MAX_POINTS),
        "point count exceeds store")

endmodule
`default_nettype wire

// ===== hdl/chs_ram.sv =====
// ============================================================================
// Generic single-port-write, single-port-read RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none
module chs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/chs_turn.sv =====
// ============================================================================
// Turn direction unit
// Registered sign of the cross product (a-o) x (b-o) with a distance tie break.
// ============================================================================
`default_nettype none
module chs_turn
    import chs_pkg::*;
#(
    parameter int CB = 16
) (
    input  wire logic          clk,
    input  wire logic [CB-1:0] ox,
    input  wire logic [CB-1:0] oy,
    input  wire logic [CB-1:0] ax,
    input  wire logic [CB-1:0] ay,
    input  wire logic [CB-1:0] bx,
    input  wire logic [CB-1:0] by,
    output logic               left,
    output logic               colin,
    output logic               nearer
);

    logic signed [CB:0]      dax, day, dbx, dby;
    logic signed [2*CB+1:0]  p1_reg, p2_reg;
    logic        [CB+1:0]    da_reg, db_reg;
    logic        [CB:0]      max, may, mbx, mby;
    logic signed [2*CB+2:0]  diff;

    always_comb
    begin
        dax = $signed({ax[CB-1], ax}) - $signed({ox[CB-1], ox});
        day = $signed({ay[CB-1], ay}) - $signed({oy[CB-1], oy});
        dbx = $signed({bx[CB-1], bx}) - $signed({ox[CB-1], ox});
        dby = $signed({by[CB-1], by}) - $signed({oy[CB-1], oy});
        max = dax[CB] ? (CB+1)'(0) - dax : dax;
        may = day[CB] ? (CB+1)'(0) - day : day;
        mbx = dbx[CB] ? (CB+1)'(0) - dbx : dbx;
        mby = dby[CB] ? (CB+1)'(0) - dby : dby;
        diff = {p1_reg[2*CB+1], p1_reg} - {p2_reg[2*CB+1], p2_reg};
        left = !diff[2*CB+2] && (diff != '0);
        colin = (diff == '0);
        nearer = da_reg < db_reg;
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= dax * dby;
        p2_reg <= day * dbx;
        da_reg <= {1'b0, max} + {1'b0, may};
        db_reg <= {1'b0, mbx} + {1'b0, mby};
    end

endmodule
`default_nettype wire
